@@ rtl/sobel_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared types and constants of the Sobel edge threshold block.
// ----------------------------------------------------------------------------
package sobel_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

	localparam int FRAME_DIM_RST = 1024;
	localparam int THRESH_RST    = 200;
	localparam int T2_W          = 22;
	localparam logic [T2_W-1:0] T2_RST = T2_W'(THRESH_RST * THRESH_RST);

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// luma = (299 R + 587 G + 114 B) / 1000, division as (sum >> 3) * ceil(2^22 / 125) >> 22
	localparam int LUMA_SUM_W = 18;
	localparam logic [LUMA_SUM_W-1:0] LUMA_R = 18'd299;
	localparam logic [LUMA_SUM_W-1:0] LUMA_G = 18'd587;
	localparam logic [LUMA_SUM_W-1:0] LUMA_B = 18'd114;
	localparam int LUMA_PRE   = 3;
	localparam int LUMA_SHIFT = 22;
	localparam int LUMA_PROD_W = 31;
	localparam logic [15:0] LUMA_RECIP = 16'd33555;

	localparam logic [7:0] EDGE_ON  = 8'hFF;
	localparam logic [7:0] EDGE_OFF = 8'h00;

	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_DEPTH   = 8;

	// index 0 is the top row of the column
	typedef logic [2:0][7:0] col_t;

	typedef struct packed {
		logic pixel;
		logic top_clamp;
		logic lc_win2;
		logic rc_fresh;
		logic produce;
	} cls_t;

	typedef struct packed {
		cls_t       cls;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} item_t;

	typedef struct packed {
		logic [7:0] edge_value;
		logic [9:0] out_x;
		logic [9:0] out_y;
		logic       last;
	} result_t;

endpackage
`default_nettype wire

@@ rtl/sobel_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sobel_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule
`default_nettype wire

@@ rtl/sobel_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_fifo
// Small flop-based FIFO with occupancy count.
// ----------------------------------------------------------------------------
module sobel_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             pop,
	input  logic [WIDTH-1:0] wr_data,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty,
	output logic             full,
	output logic [CW-1:0]    count
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = count_q == '0;
	assign full    = count_q == CW'(DEPTH);
	assign count   = count_q;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

@@ rtl/sobel_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_front
// Takes input items, tracks the raster position and classifies each item
// for the window logic; drain items that arrive during pixels are dropped.
// ----------------------------------------------------------------------------
module sobel_front #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024,
	localparam int AW = $clog2(MAX_WIDTH),
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [WW-1:0]     frame_w,
	input  logic [HW-1:0]     frame_h,
	input  logic              geom_clr,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	input  logic              q_full,
	output logic              q_push,
	output sobel_pkg::item_t  q_item,
	output logic [AW-1:0]     q_col
);

	import sobel_pkg::*;

	localparam int RW = $clog2(MAX_HEIGHT + 2);

	logic [AW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [RW-1:0] h_ext;
	logic          accept;
	logic          pixel;
	logic          col_end;
	logic          frame_end;

	assign h_ext     = RW'(frame_h);
	assign pixel     = row_q < h_ext;
	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign q_push    = accept && !(pixel && cmd == CMD_DRAIN);
	assign col_end   = (WW'(col_q) + WW'(1)) == frame_w;
	assign frame_end = (row_q == h_ext + RW'(1)) && (col_q == '0);

	always_comb begin
		q_item.cls.pixel     = pixel;
		q_item.cls.top_clamp = row_q <= RW'(1);
		q_item.cls.lc_win2   = (col_q == '0) ? (frame_w == WW'(1)) : (col_q == AW'(1));
		q_item.cls.rc_fresh  = col_q != '0;
		q_item.cls.produce   = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
		q_item.red           = red;
		q_item.green         = green;
		q_item.blue          = blue;
		q_col                = col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (geom_clr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_end) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= h_ext + RW'(1))
		else $error("raster row past the drain row");

endmodule
`default_nettype wire

@@ rtl/sobel_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_back
// Luma conversion, line buffers, 3x3 window, Sobel gradient and threshold.
// Free-running pipeline; items that produce a result enter only with room
// reserved in the output queue.
// ----------------------------------------------------------------------------
module sobel_back #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024,
	localparam int AW = $clog2(MAX_WIDTH),
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [WW-1:0]              frame_w,
	input  logic [HW-1:0]              frame_h,
	input  logic [sobel_pkg::T2_W-1:0] thresh_sq,
	input  logic                       geom_clr,
	input  logic                       q_empty,
	output logic                       q_pop,
	input  sobel_pkg::item_t           q_item,
	input  logic [AW-1:0]              q_col,
	output logic                       out_valid,
	input  logic                       out_ready,
	output sobel_pkg::result_t         out_res
);

	import sobel_pkg::*;

	localparam int HA  = $clog2(MAX_HEIGHT);
	localparam int OCW = $clog2(OUT_DEPTH + 1);
	localparam int CW  = OCW + 1;

	function automatic logic [9:0] wsum(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		return 10'(a) + 10'({b, 1'b0}) + 10'(c);
	endfunction

	function automatic logic [9:0] absdiff(input logic [9:0] a, input logic [9:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	// credit check against the output queue
	logic [OCW-1:0] oq_count;
	logic           oq_full;
	logic           oq_empty;
	logic           oq_push;
	logic [2:0]     inflight;
	logic [CW-1:0]  credit_used;

	// stage registers
	logic                  valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	cls_t                  cls_s1, cls_s2;
	logic [AW-1:0]         col_s1, col_s2;
	logic [LUMA_SUM_W-1:0] sum_s1;
	logic [7:0]            luma_s2;
	logic                  fwd_s2;
	logic [15:0]           fwd_data_s2;
	col_t                  lc_s3, mc_s3, rc_s3;
	logic [9:0]            ax_s4, ay_s4;
	logic [19:0]           sqx_s5, sqy_s5;

	col_t                   win_q [3];
	logic [AW-1:0]          x_q;
	logic [HA-1:0]          y_q;

	logic [LUMA_SUM_W-1:0]  sum_next;
	logic [LUMA_PROD_W-1:0] luma_prod;
	logic [15:0]            rd_data;
	logic [15:0]            lines;
	logic [7:0]             mid;
	logic [7:0]             up;
	col_t                   fresh;
	logic                   wr_en_s2;
	logic [15:0]            wr_data_s2;
	logic [9:0]             wl, wr, tw, bw;
	logic [20:0]            mag;
	logic                   x_end, y_end;
	result_t                res;

	assign inflight = 3'($countones({valid_s1 && cls_s1.produce, valid_s2 && cls_s2.produce,
		valid_s3, valid_s4, valid_s5}));
	assign credit_used = CW'(oq_count) + CW'(inflight);
	assign q_pop = !q_empty && (!q_item.cls.produce || credit_used < CW'(OUT_DEPTH));

	assign sum_next = LUMA_R * LUMA_SUM_W'(q_item.red) + LUMA_G * LUMA_SUM_W'(q_item.green)
		+ LUMA_B * LUMA_SUM_W'(q_item.blue);
	assign luma_prod = LUMA_PROD_W'(sum_s1[LUMA_SUM_W-1:LUMA_PRE]) * LUMA_PROD_W'(LUMA_RECIP);

	// line buffers: [15:8] upper line, [7:0] middle line
	sobel_ram #(
		.WIDTH(16),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk     (clk),
		.wr_en   (wr_en_s2),
		.wr_addr (col_s2),
		.wr_data (wr_data_s2),
		.rd_en   (valid_s1),
		.rd_addr (col_s1),
		.rd_data (rd_data)
	);

	always_comb begin
		lines      = fwd_s2 ? fwd_data_s2 : rd_data;
		up         = lines[15:8];
		mid        = lines[7:0];
		fresh[0]   = cls_s2.top_clamp ? mid : up;
		fresh[1]   = mid;
		fresh[2]   = cls_s2.pixel ? luma_s2 : mid;
		wr_en_s2   = valid_s2 && cls_s2.pixel;
		wr_data_s2 = {mid, luma_s2};
	end

	always_comb begin
		wl = wsum(lc_s3[0], lc_s3[1], lc_s3[2]);
		wr = wsum(rc_s3[0], rc_s3[1], rc_s3[2]);
		tw = wsum(lc_s3[0], mc_s3[0], rc_s3[0]);
		bw = wsum(lc_s3[2], mc_s3[2], rc_s3[2]);
	end

	always_comb begin
		mag            = 21'(sqx_s5) + 21'(sqy_s5);
		x_end          = (WW'(x_q) + WW'(1)) == frame_w;
		y_end          = (HW'(y_q) + HW'(1)) == frame_h;
		res.edge_value = ({1'b0, mag} > thresh_sq) ? EDGE_ON : EDGE_OFF;
		res.out_x      = 10'(x_q);
		res.out_y      = 10'(y_q);
		res.last       = x_end && y_end;
	end

	assign oq_push = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			win_q[0] <= '0;
			win_q[1] <= '0;
			win_q[2] <= '0;
			x_q      <= '0;
			y_q      <= '0;
		end else begin
			valid_s1 <= q_pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2 && cls_s2.produce;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			if (valid_s2) begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= fresh;
			end
			if (geom_clr) begin
				x_q <= '0;
				y_q <= '0;
			end else if (oq_push) begin
				if (x_end) begin
					x_q <= '0;
					y_q <= y_end ? '0 : y_q + HA'(1);
				end else begin
					x_q <= x_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		cls_s1      <= q_item.cls;
		col_s1      <= q_col;
		sum_s1      <= sum_next;
		cls_s2      <= cls_s1;
		col_s2      <= col_s1;
		luma_s2     <= luma_prod[LUMA_SHIFT +: 8];
		// write of the item ahead lands in the same cycle as this read
		fwd_s2      <= wr_en_s2 && (col_s2 == col_s1);
		fwd_data_s2 <= wr_data_s2;
		lc_s3       <= cls_s2.lc_win2 ? win_q[2] : win_q[1];
		mc_s3       <= win_q[2];
		rc_s3       <= cls_s2.rc_fresh ? fresh : win_q[2];
		ax_s4       <= absdiff(wr, wl);
		ay_s4       <= absdiff(bw, tw);
		sqx_s5      <= ax_s4 * ax_s4;
		sqy_s5      <= ay_s4 * ay_s4;
	end

	sobel_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (oq_push),
		.pop     (out_valid && out_ready),
		.wr_data (res),
		.rd_data (out_res),
		.empty   (oq_empty),
		.full    (oq_full),
		.count   (oq_count)
	);

	assign out_valid = !oq_empty;

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_used <= CW'(OUT_DEPTH))
		else $error("output queue over-committed");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> !oq_full)
		else $error("result reached a full output queue");

	a_last_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(oq_push && res.last) |=> (x_q == '0 && y_q == '0))
		else $error("result position did not wrap after last");

endmodule
`default_nettype wire

@@ rtl/sobel_edge_threshold.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_edge_threshold
// Streaming 3x3 Sobel edge detector on luma with a squared-magnitude
// threshold and replicated frame borders.
//
// Channel   Handshake              Payload
// in        in_valid / in_ready    cmd, red, green, blue
// out       out_valid / out_ready  edge_value, out_x, out_y, last
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per clock sustained while the output keeps up; the line RAM does one
// read per item and one write per pixel item, which sets that rate.
// A result passes the item queue, the pipeline stages and the output queue
// before it is offered at the output.
// Reset clears control registers and the window; line RAM contents and pipeline data registers are not cleared.
// A 4-entry item queue parts the front from the pipeline; an 8-entry output
// queue with credit tracking holds results through short output stalls, and a
// longer stall backs up into the item queue and then stops input.
// ----------------------------------------------------------------------------
module sobel_edge_threshold #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             cmd,
	input  logic [7:0]                       red,
	input  logic [7:0]                       green,
	input  logic [7:0]                       blue,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       edge_value,
	output logic [9:0]                       out_x,
	output logic [9:0]                       out_y,
	output logic                             last,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sobel_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sobel_pkg::CFG_DATA_W-1:0] cfg_data
);

	import sobel_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int W_RST = (FRAME_DIM_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_DIM_RST;
	localparam int H_RST = (FRAME_DIM_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_DIM_RST;
	localparam int ITEM_W = $bits(item_t);
	localparam int QW = ITEM_W + AW;

	logic [WW-1:0]   w_q;
	logic [HW-1:0]   h_q;
	logic [T2_W-1:0] t2_q;
	logic [WW-1:0]   w_new;
	logic [HW-1:0]   h_new;
	logic            geom_clr;

	logic            f_push;
	item_t           f_item;
	logic [AW-1:0]   f_col;
	logic            q_full;
	logic            q_empty;
	logic            q_pop;
	logic [QW-1:0]   q_rd_data;
	item_t           head_item;
	logic [AW-1:0]   head_col;
	result_t         out_res;

	assign cfg_ready = 1'b1;
	assign geom_clr  = cfg_valid
		&& (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

	always_comb begin
		if (cfg_data == '0) begin
			w_new = WW'(1);
		end else if (32'(cfg_data) > MAX_WIDTH) begin
			w_new = WW'(MAX_WIDTH);
		end else begin
			w_new = WW'(cfg_data);
		end
		if (cfg_data == '0) begin
			h_new = HW'(1);
		end else if (32'(cfg_data) > MAX_HEIGHT) begin
			h_new = HW'(MAX_HEIGHT);
		end else begin
			h_new = HW'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q  <= WW'(W_RST);
			h_q  <= HW'(H_RST);
			t2_q <= T2_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH: begin
					w_q <= w_new;
				end
				REG_FRAME_HEIGHT: begin
					h_q <= h_new;
				end
				REG_EDGE_THRESHOLD: begin
					t2_q <= T2_W'(cfg_data) * T2_W'(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	sobel_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame_w  (w_q),
		.frame_h  (h_q),
		.geom_clr (geom_clr),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.q_full   (q_full),
		.q_push   (f_push),
		.q_item   (f_item),
		.q_col    (f_col)
	);

	sobel_fifo #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_item_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (f_push),
		.pop     (q_pop),
		.wr_data ({f_col, f_item}),
		.rd_data (q_rd_data),
		.empty   (q_empty),
		.full    (q_full),
		.count   ()
	);

	assign head_item = item_t'(q_rd_data[ITEM_W-1:0]);
	assign head_col  = q_rd_data[QW-1:ITEM_W];

	sobel_back #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame_w   (w_q),
		.frame_h   (h_q),
		.thresh_sq (t2_q),
		.geom_clr  (geom_clr),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_item    (head_item),
		.q_col     (head_col),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign edge_value = out_res.edge_value;
	assign out_x      = out_res.out_x;
	assign out_y      = out_res.out_y;
	assign last       = out_res.last;

endmodule
`default_nettype wire

@@ bench/sobel_edge_threshold_tb.sv @@
// ----------------------------------------------------------------------------
// sobel_edge_threshold_tb
// Self-checking bench for the streaming Sobel edge threshold block. Frames of
// RGB pixels with drain items are fed through a valid/ready driver. A local
// line-buffer and window model predicts every edge result, and the monitor
// checks each result field by field. Geometry and threshold change between
// phases, from a short directed part to random frames of mostly small size.
// Both handshakes idle at random, and one long output hold back-pressures
// the input.
// ----------------------------------------------------------------------------
module sobel_edge_threshold_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sobel_pkg::*;

	localparam int MAX_W          = 1024;
	localparam int MAX_H          = 1024;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 32;
	localparam int RANDOM_ITEMS   = 500;
	localparam int unsigned WHOLE_FRAME = 32'hFFFF_FFFF;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic       cmd;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = CMD_PIXEL;
	logic [7:0] red = '0;
	logic [7:0] green = '0;
	logic [7:0] blue = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] edge_value;
	logic [9:0] out_x;
	logic [9:0] out_y;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// model state
	logic [7:0] upper_row [MAX_W];
	logic [7:0] middle_row [MAX_W];
	col_t luma_cols [3];
	int unsigned frame_pos = 0;
	int unsigned result_pos = 0;
	logic [CFG_DATA_W-1:0] width_reg = CFG_DATA_W'(FRAME_DIM_RST);
	logic [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(FRAME_DIM_RST);
	logic [CFG_DATA_W-1:0] thresh_reg = CFG_DATA_W'(THRESH_RST);

	pixel_item_t pixel_q [$];
	result_t edge_q [$];
	pixel_item_t cur_item;
	result_t want;

	int unsigned queued_total = 0;
	int unsigned accepted_total = 0;
	int unsigned ignored_items = 0;
	int unsigned results_seen = 0;
	int unsigned edges_seen = 0;
	int unsigned frames_done = 0;
	int unsigned cfg_writes = 0;
	int unsigned errors = 0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	int hold_asked = 0;
	int hold_served = 0;
	int quiet = 0;
	bit idle_on = 1'b1;

	sobel_edge_threshold uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.edge_value (edge_value),
		.out_x      (out_x),
		.out_y      (out_y),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned clamp_size(logic [CFG_DATA_W-1:0] v, int unsigned top);
		if (v == 0)
			return 1;
		if (v > top)
			return top;
		return v;
	endfunction

	function automatic int col_sum(col_t c);
		return int'(c[0]) + 2 * int'(c[1]) + int'(c[2]);
	endfunction

	function automatic logic [7:0] edge_decision(col_t lc, col_t mc, col_t rc);
		int gx, gy, t;
		gx = col_sum(rc) - col_sum(lc);
		gy = (int'(lc[2]) + 2 * int'(mc[2]) + int'(rc[2]))
			- (int'(lc[0]) + 2 * int'(mc[0]) + int'(rc[0]));
		t = int'(thresh_reg);
		return (gx * gx + gy * gy > t * t) ? EDGE_ON : EDGE_OFF;
	endfunction

	function automatic void queue_result(logic [7:0] v, int unsigned w, int unsigned pixels);
		result_t res;
		res.edge_value = v;
		res.out_x = 10'(result_pos % w);
		res.out_y = 10'(result_pos / w);
		res.last = (result_pos == pixels - 1);
		edge_q.push_back(res);
		result_pos++;
	endfunction

	function automatic void sobel_predict(pixel_item_t it);
		int unsigned w, h, pixels, total, n, c, r, luma;
		logic produce;
		col_t fresh;
		w = clamp_size(width_reg, MAX_W);
		h = clamp_size(height_reg, MAX_H);
		pixels = w * h;
		total = pixels + w + 1;
		n = frame_pos;
		luma = 0;
		if (n >= total) begin
			n = 0;
			result_pos = 0;
		end
		if (n < pixels && it.cmd == CMD_DRAIN) begin
			ignored_items++;
			return;
		end
		c = n % w;
		r = n / w;
		produce = (n >= w + 1);
		if (n < pixels)
			luma = (299 * it.red + 587 * it.green + 114 * it.blue) / 1000;
		// right border: last column replicated
		if (c == 0 && produce)
			queue_result(edge_decision((w == 1) ? luma_cols[2] : luma_cols[1],
				luma_cols[2], luma_cols[2]), w, pixels);
		fresh[0] = (r <= 1) ? middle_row[c] : upper_row[c];
		fresh[1] = middle_row[c];
		fresh[2] = (r < h) ? 8'(luma) : middle_row[c];
		luma_cols[0] = luma_cols[1];
		luma_cols[1] = luma_cols[2];
		luma_cols[2] = fresh;
		if (r < h) begin
			upper_row[c] = middle_row[c];
			middle_row[c] = 8'(luma);
		end
		// left border: column 0 replicated
		if (c >= 1 && produce)
			queue_result(edge_decision((c == 1) ? luma_cols[1] : luma_cols[0],
				luma_cols[1], luma_cols[2]), w, pixels);
		n++;
		if (n >= total) begin
			n = 0;
			result_pos = 0;
		end
		frame_pos = n;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		case (idx)
			REG_FRAME_WIDTH: begin
				width_reg = v;
				frame_pos = 0;
				result_pos = 0;
			end
			REG_FRAME_HEIGHT: begin
				height_reg = v;
				frame_pos = 0;
				result_pos = 0;
			end
			REG_EDGE_THRESHOLD: thresh_reg = v;
			default: ;
		endcase
	endfunction

	function automatic void push_item(logic c, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		pixel_item_t it;
		it.cmd = c;
		it.red = r;
		it.green = g;
		it.blue = b;
		pixel_q.push_back(it);
		queued_total++;
	endfunction

	// one frame of pixels, cut short after `cut` pixels, else followed by its drain
	function automatic int unsigned push_frame(int unsigned w, int unsigned h,
			int unsigned cut, int unsigned style);
		int unsigned pixels, k, x, y, sx, sy, counted;
		logic [7:0] hi, lo, v, cr, cg, cb;
		pixels = w * h;
		sx = $urandom_range(0, w);
		sy = $urandom_range(0, h);
		hi = 8'($urandom_range(128, 255));
		lo = 8'($urandom_range(0, 127));
		cr = 8'($urandom);
		cg = 8'($urandom);
		cb = 8'($urandom);
		counted = 0;
		for (k = 0; k < pixels && k < cut; k++) begin
			if ($urandom_range(0, 99) < 4)
				push_item(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
			x = k % w;
			y = k / w;
			case (style)
				0: push_item(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
				1: begin
					v = ((x >= sx) ^ (y >= sy)) ? hi : lo;
					push_item(CMD_PIXEL, v, v, v);
				end
				default: begin
					if ($urandom_range(0, 15) == 0)
						push_item(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
					else
						push_item(CMD_PIXEL, cr, cg, cb);
				end
			endcase
			counted++;
		end
		if (cut >= pixels) begin
			for (k = 0; k <= w; k++) begin
				// a pixel item here acts as a drain
				if ($urandom_range(0, 3) == 0)
					push_item(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
				else
					push_item(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
				counted++;
			end
		end
		return counted;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_reg(idx, v);
		cfg_writes++;
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (accepted_total != queued_total || edge_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// input driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sobel_predict(cur_item);
				accepted_total++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pixel_q.size() != 0 && idle_on && $urandom_range(0, 99) < 6) begin
					send_gap = $urandom_range(0, 17);
					in_valid <= 1'b0;
				end else if (pixel_q.size() != 0) begin
					cur_item = pixel_q.pop_front();
					in_valid <= 1'b1;
					cmd <= cur_item.cmd;
					red <= cur_item.red;
					green <= cur_item.green;
					blue <= cur_item.blue;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and output back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (edge_q.size() == 0) begin
					$error("result with none expected: x=%0d y=%0d", out_x, out_y);
					errors++;
				end else begin
					want = edge_q.pop_front();
					if (edge_value !== want.edge_value) begin
						$error("edge_value: expected %0d, actual %0d", want.edge_value, edge_value);
						errors++;
					end
					if (out_x !== want.out_x) begin
						$error("out_x: expected %0d, actual %0d", want.out_x, out_x);
						errors++;
					end
					if (out_y !== want.out_y) begin
						$error("out_y: expected %0d, actual %0d", want.out_y, out_y);
						errors++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, last);
						errors++;
					end
					results_seen++;
					if (want.edge_value == EDGE_ON)
						edges_seen++;
					if (want.last)
						frames_done++;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_served != hold_asked && out_valid) begin
				hold_served++;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 99) < 6) begin
				stall_left = $urandom_range(0, 17);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("FAIL sobel_edge_threshold");
				$finish;
			end
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] wr, hr, tr;
		int unsigned w, h, nf, f, style, counted_small;
		counted_small = 0;
		foreach (upper_row[i]) begin
			upper_row[i] = '0;
			middle_row[i] = '0;
		end
		foreach (luma_cols[i])
			luma_cols[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 3x3 frame, threshold changed from 0 to full scale mid-frame
		write_reg(REG_SPARE, 11'h5A5);
		write_reg(REG_FRAME_WIDTH, 11'd3);
		write_reg(REG_FRAME_HEIGHT, 11'd3);
		write_reg(REG_EDGE_THRESHOLD, 11'd0);
		push_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0);
		push_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
		push_item(CMD_PIXEL, 8'd255, 8'd0, 8'd0);
		push_item(CMD_PIXEL, 8'd0, 8'd255, 8'd0);
		push_item(CMD_PIXEL, 8'd0, 8'd0, 8'd255);
		wait_idle();
		write_reg(REG_EDGE_THRESHOLD, 11'd2047);
		push_item(CMD_DRAIN, 8'd255, 8'd255, 8'd255);
		push_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
		push_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0);
		push_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0);
		push_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
		push_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
		push_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
		push_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
		push_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
		wait_idle();
		// 2x2 frame, then a geometry write in the middle of it restarts the frame
		write_reg(REG_FRAME_WIDTH, 11'd2);
		write_reg(REG_FRAME_HEIGHT, 11'd2);
		write_reg(REG_EDGE_THRESHOLD, 11'd100);
		push_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
		push_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0);
		push_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
		wait_idle();
		write_reg(REG_FRAME_HEIGHT, 11'd0);
		push_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0);
		push_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
		push_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
		push_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
		push_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
		wait_idle();

		// one column, height clamped, with a long output hold
		write_reg(REG_FRAME_WIDTH, 11'd0);
		write_reg(REG_FRAME_HEIGHT, 11'd2047);
		write_reg(REG_EDGE_THRESHOLD, 11'd80);
		hold_asked++;
		void'(push_frame(1, 1024, WHOLE_FRAME, 1));
		wait_idle();

		while (counted_small < RANDOM_ITEMS) begin
			if (counted_small > RANDOM_ITEMS - 200)
				idle_on = 1'b0;
			wr = ($urandom_range(0, 11) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 10));
			hr = ($urandom_range(0, 11) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 7));
			write_reg(REG_FRAME_WIDTH, wr);
			write_reg(REG_FRAME_HEIGHT, hr);
			if ($urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 9))
					0: tr = '0;
					1: tr = '1;
					2: tr = 11'd1500;
					default: tr = CFG_DATA_W'($urandom_range(20, 400));
				endcase
				write_reg(REG_EDGE_THRESHOLD, tr);
			end
			w = clamp_size(wr, MAX_W);
			h = clamp_size(hr, MAX_H);
			nf = $urandom_range(1, 3);
			for (f = 0; f < nf; f++) begin
				style = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2);
				if ($urandom_range(0, 9) == 0) begin
					counted_small += push_frame(w, h, $urandom_range(0, w * h - 1), style);
					break;
				end
				counted_small += push_frame(w, h, WHOLE_FRAME, style);
			end
			wait_idle();
		end

		$display("Run fed %0d items (%0d ignored drains) over %0d register writes.",
			accepted_total, ignored_items, cfg_writes);
		$display("Checked %0d results, %0d of them edges, across %0d finished frames.",
			results_seen, edges_seen, frames_done);
		if (errors == 0)
			$display("PASS sobel_edge_threshold");
		else
			$display("FAIL sobel_edge_threshold");
		$finish;
	end

endmodule
